### src/iwl_pkg.sv
// ----------------------------------------------------------------------------
// iwl_pkg: shared definitions for the interpolated wavetable lookup core
// Command and register codes, size constants, front-end states and the
// saturating Q31 helper used by the back end.
// ----------------------------------------------------------------------------
package iwl_pkg;

    // Default table storage depth and the transaction queue depth
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Field widths fixed by the interface
    localparam int SIZE_W   = 11;
    localparam int ADDR_W   = 10;
    localparam int SAMPLE_W = 32;
    localparam int PHASE_W  = 32;
    localparam int WHOLE_W  = 16;
    localparam int FRAC_W   = 16;

    // One remainder bit per divide step, one step per integer phase bit
    localparam int DIV_STEPS = WHOLE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Configuration register indexes
    localparam int   CFG_IDX_W      = 1;
    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_FAST_MODE  = 1'b1;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;

    // Q31 limits
    localparam logic signed [SAMPLE_W-1:0] Q31_MAX = 32'sh7fff_ffff;
    localparam logic signed [SAMPLE_W-1:0] Q31_MIN = 32'sh8000_0000;

    // Front-end sequencer states
    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIVIDE,
        FS_PUSH
    } fstate_t;

    // Saturate a 34-bit signed value into the Q31 range
    function automatic logic signed [SAMPLE_W-1:0] sat_q31(input logic signed [33:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 34'(Q31_MAX)) begin
            r = Q31_MAX;
        end
        else if (v < 34'(Q31_MIN)) begin
            r = Q31_MIN;
        end
        else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/iwl_front.sv
// ----------------------------------------------------------------------------
// iwl_front: input side of the wavetable lookup core
// Accepts transactions, drops out-of-range writes, wraps the phase index to
// the table size (mask in fast mode, iterative modulo in precise mode) and
// pushes a packed entry into the transaction queue.
// ----------------------------------------------------------------------------
module iwl_front #(
    parameter int TABLE_DEPTH = iwl_pkg::TABLE_DEPTH_DEF,
    parameter int ENTRY_W     = 2 + 2 * $clog2(TABLE_DEPTH) + 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic [iwl_pkg::ADDR_W-1:0]  entry_address,
    input  logic [31:0]                 entry_value,
    input  logic [iwl_pkg::PHASE_W-1:0] phase_index,
    // Configuration
    input  logic [iwl_pkg::SIZE_W-1:0]  eff_size,
    input  logic                        fast_mode,
    // Queue push side
    input  logic                        q_full,
    output logic                        q_push,
    output logic [ENTRY_W-1:0]          q_data
);
    import iwl_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    fstate_t                state_reg, state_next;
    logic [WHOLE_W-1:0]     whole_reg;
    logic [FRAC_W-1:0]      frac_reg;
    logic [SIZE_W-1:0]      rem_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;

    logic                   accept;
    logic                   write_ok;
    logic [SIZE_W-1:0]      mask;
    logic [WHOLE_W-1:0]     whole_in;
    logic [WHOLE_W-1:0]     whole_inc;
    logic [SIZE_W-1:0]      fast_ia;
    logic [SIZE_W-1:0]      fast_ib;
    logic [SIZE_W:0]        trial;
    logic [SIZE_W-1:0]      rem_step;
    logic [SIZE_W:0]        rem_inc;
    logic [SIZE_W-1:0]      prec_ib;
    logic                   e_cmd;
    logic                   e_fast;
    logic [IDX_W-1:0]       e_ia;
    logic [IDX_W-1:0]       e_ib;
    logic [31:0]            e_value;
    logic [FRAC_W-1:0]      e_frac;

    assign accept   = in_valid && !in_stall;
    assign write_ok = 32'(entry_address) < 32'(TABLE_DEPTH);

    // Mask wrap for fast mode
    assign mask      = eff_size - SIZE_W'(1);
    assign whole_in  = phase_index[PHASE_W-1 -: WHOLE_W];
    assign whole_inc = whole_in + WHOLE_W'(1);
    assign fast_ia   = whole_in[SIZE_W-1:0] & mask;
    assign fast_ib   = whole_inc[SIZE_W-1:0] & mask;

    // One restoring modulo step: shift in the next integer bit
    always_comb
    begin
        trial = {rem_reg, whole_reg[WHOLE_W-1]};
        if (trial >= {1'b0, eff_size}) begin
            trial = trial - {1'b0, eff_size};
        end
        rem_step = trial[SIZE_W-1:0];
    end

    // Second index in precise mode wraps back to zero at the size
    assign rem_inc = {1'b0, rem_reg} + (SIZE_W + 1)'(1);
    assign prec_ib = (rem_inc == {1'b0, eff_size}) ? '0 : rem_inc[SIZE_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (accept && command == CMD_LOOKUP && !fast_mode) begin
                    state_next = FS_DIVIDE;
                end
            end
            FS_DIVIDE:
            begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = FS_PUSH;
                end
            end
            FS_PUSH:
            begin
                if (!q_full) begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // Outputs: stall, push and the entry contents
    always_comb
    begin
        in_stall = (state_reg != FS_IDLE) || q_full;
        q_push   = 1'b0;
        e_cmd    = CMD_LOOKUP;
        e_fast   = fast_mode;
        e_ia     = '0;
        e_ib     = '0;
        e_value  = '0;
        e_frac   = frac_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                e_cmd   = command;
                e_value = entry_value;
                e_frac  = phase_index[FRAC_W-1:0];
                if (command == CMD_WRITE) begin
                    e_ia   = IDX_W'(32'(entry_address));
                    q_push = accept && write_ok;
                end
                else begin
                    e_ia   = IDX_W'(32'(fast_ia));
                    e_ib   = IDX_W'(32'(fast_ib));
                    q_push = accept && fast_mode;
                end
            end
            FS_DIVIDE:
            begin
                q_push = 1'b0;
            end
            FS_PUSH:
            begin
                e_fast = 1'b0;
                e_ia   = IDX_W'(32'(rem_reg));
                e_ib   = IDX_W'(32'(prec_ib));
                q_push = !q_full;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    assign q_data = {e_cmd, e_fast, e_ia, e_ib, e_value, e_frac};

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= FS_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // Divider datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == FS_IDLE && accept) begin
            whole_reg <= whole_in;
            frac_reg  <= phase_index[FRAC_W-1:0];
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (state_reg == FS_DIVIDE) begin
            whole_reg <= {whole_reg[WHOLE_W-2:0], 1'b0};
            rem_reg   <= rem_step;
            cnt_reg   <= cnt_reg + DIV_CNT_W'(1);
        end
    end

endmodule

### src/iwl_queue.sv
// ----------------------------------------------------------------------------
// iwl_queue: transaction queue between front and back end
// Small synchronous FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module iwl_queue #(
    parameter int DEPTH = iwl_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic             full
);
    import iwl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = slots[rd_ptr_reg];

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

### src/iwl_back.sv
// ----------------------------------------------------------------------------
// iwl_back: table storage and interpolation pipeline
// Pops queued transactions, writes table entries, and runs lookups through
// read, difference, multiply and accumulate stages into the output register.
// ----------------------------------------------------------------------------
module iwl_back #(
    parameter int TABLE_DEPTH = iwl_pkg::TABLE_DEPTH_DEF,
    parameter int ENTRY_W     = 2 + 2 * $clog2(TABLE_DEPTH) + 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Queue pop side
    input  logic [ENTRY_W-1:0]           q_head,
    input  logic                         q_empty,
    output logic                         q_pop,
    // Output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [iwl_pkg::SAMPLE_W-1:0] sample
);
    import iwl_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int VAL_LSB = FRAC_W;
    localparam int IB_LSB  = FRAC_W + 32;
    localparam int IA_LSB  = IB_LSB + IDX_W;
    localparam int FST_BIT = IA_LSB + IDX_W;
    localparam int CMD_BIT = FST_BIT + 1;
    localparam int PROD_W  = 50;

    // Table storage, undefined until written
    logic [31:0]                 table_mem [TABLE_DEPTH];

    logic                        advance;
    logic                        h_cmd;
    logic                        h_fast;
    logic [IDX_W-1:0]            h_ia;
    logic [IDX_W-1:0]            h_ib;
    logic [31:0]                 h_value;
    logic [FRAC_W-1:0]           h_frac;

    // Stage 1: table read
    logic                        v1_reg;
    logic signed [31:0]          rd_a_reg;
    logic signed [31:0]          rd_b_reg;
    logic [FRAC_W-1:0]           frac1_reg;
    logic                        fast1_reg;
    // Stage 2: saturated difference
    logic                        v2_reg;
    logic signed [31:0]          a2_reg;
    logic signed [31:0]          d2_reg;
    logic [FRAC_W-1:0]           frac2_reg;
    logic                        fast2_reg;
    // Stage 3: product
    logic                        v3_reg;
    logic signed [31:0]          a3_reg;
    logic signed [PROD_W-1:0]    prod3_reg;
    logic                        fast3_reg;
    // Stage 4: output register
    logic                        out_valid_reg;
    logic signed [SAMPLE_W-1:0]  sample_reg;

    logic signed [SAMPLE_W-1:0]  diff;
    logic signed [32:0]          mul_x;
    logic signed [16:0]          mul_y;
    logic signed [PROD_W-1:0]    prod;
    logic signed [32:0]          delta;
    logic signed [33:0]          sum;

    // Unpack queue head
    assign h_frac  = q_head[FRAC_W-1:0];
    assign h_value = q_head[VAL_LSB +: 32];
    assign h_ib    = q_head[IB_LSB +: IDX_W];
    assign h_ia    = q_head[IA_LSB +: IDX_W];
    assign h_fast  = q_head[FST_BIT];
    assign h_cmd   = q_head[CMD_BIT];

    // Whole pipeline moves unless a finished result is held
    assign advance = !(out_valid_reg && out_stall);
    assign q_pop   = advance && !q_empty;

    // Table write and two-address registered read
    always_ff @(posedge clk)
    begin
        if (q_pop && h_cmd == CMD_WRITE) begin
            table_mem[h_ia] <= h_value;
        end
        if (advance) begin
            rd_a_reg <= table_mem[h_ia];
            rd_b_reg <= table_mem[h_ib];
        end
    end

    // Difference b - a, saturated
    assign diff = sat_q31(34'(rd_b_reg) - 34'(rd_a_reg));

    // Shared multiplier: precise d*frac, fast (d>>16)*(frac with lsb cleared)
    always_comb
    begin
        if (fast2_reg) begin
            mul_x = 33'(d2_reg >>> 16);
            mul_y = {1'b0, frac2_reg[FRAC_W-1:1], 1'b0};
        end
        else begin
            mul_x = 33'(d2_reg);
            mul_y = {1'b0, frac2_reg};
        end
        prod = PROD_W'(mul_x) * PROD_W'(mul_y);
    end

    // Scale the product and accumulate onto a
    assign delta = fast3_reg ? prod3_reg[32:0] : prod3_reg[48:16];
    assign sum   = 34'(a3_reg) + 34'(delta);

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            v1_reg        <= q_pop && (h_cmd == CMD_LOOKUP);
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (advance) begin
            frac1_reg  <= h_frac;
            fast1_reg  <= h_fast;
            a2_reg     <= rd_a_reg;
            d2_reg     <= diff;
            frac2_reg  <= frac1_reg;
            fast2_reg  <= fast1_reg;
            a3_reg     <= a2_reg;
            prod3_reg  <= prod;
            fast3_reg  <= fast2_reg;
            sample_reg <= sat_q31(sum);
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule

### src/interpolated_wavetable_lookup_core.sv
// ----------------------------------------------------------------------------
// interpolated_wavetable_lookup_core: linear interpolated wavetable lookup
// Q31 sample table with write transactions and 16.16 phase lookups.
// ----------------------------------------------------------------------------
// Writes and fast-mode lookups are taken back to back from the idle state
// unless the queue is full. A precise-mode lookup occupies the input while
// the one-bit-per-cycle modulo unit wraps the 16-bit integer phase to the
// table size: an accept, 16 divide steps and a queue push. A popped lookup
// passes the table read, difference, multiply and accumulate stages into
// the output register; the pipeline holds while a stalled result waits.
// Writes to addresses at or beyond TABLE_DEPTH are dropped; a table size
// of zero acts as one, and a size above TABLE_DEPTH acts as TABLE_DEPTH.
// The table holds no reset value: looking up a never-written entry returns
// an unspecified sample. The user must write configuration only while no
// transaction is in flight; the core does not enforce this.
// ----------------------------------------------------------------------------
module interpolated_wavetable_lookup_core #(
    parameter int TABLE_DEPTH = iwl_pkg::TABLE_DEPTH_DEF,
    parameter int QUEUE_DEPTH = iwl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [iwl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iwl_pkg::SIZE_W-1:0]     cfg_data,
    // Input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           command,
    input  logic [iwl_pkg::ADDR_W-1:0]     entry_address,
    input  logic signed [31:0]             entry_value,
    input  logic [iwl_pkg::PHASE_W-1:0]    phase_index,
    // Output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [iwl_pkg::SAMPLE_W-1:0] sample
);
    import iwl_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W = 2 + 2 * IDX_W + 32 + FRAC_W;

    logic [SIZE_W-1:0]  table_size_reg;
    logic               fast_mode_reg;
    logic [SIZE_W-1:0]  eff_size;

    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_data;
    logic [ENTRY_W-1:0] q_head;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            table_size_reg <= TABLE_SIZE_RST;
            fast_mode_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TABLE_SIZE: table_size_reg <= cfg_data;
                REG_FAST_MODE:  fast_mode_reg  <= cfg_data[0];
                default:        fast_mode_reg  <= fast_mode_reg;
            endcase
        end
    end

    // Clamp the table size into 1..TABLE_DEPTH
    always_comb
    begin
        if (table_size_reg == '0) begin
            eff_size = SIZE_W'(1);
        end
        else if (32'(table_size_reg) > 32'(TABLE_DEPTH)) begin
            eff_size = SIZE_W'(TABLE_DEPTH);
        end
        else begin
            eff_size = table_size_reg;
        end
    end

    iwl_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .entry_address (entry_address),
        .entry_value   (entry_value),
        .phase_index   (phase_index),
        .eff_size      (eff_size),
        .fast_mode     (fast_mode_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_data)
    );

    iwl_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    iwl_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample)
    );

endmodule

### src/iwl_checker.sv
// ----------------------------------------------------------------------------
// iwl_checker: port-level assertions for the wavetable lookup core
// Tracks outstanding lookups and the fast-mode setting from the ports.
// ----------------------------------------------------------------------------
module iwl_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [iwl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [iwl_pkg::SIZE_W-1:0]     cfg_data,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           command,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [iwl_pkg::SAMPLE_W-1:0]   sample
);
    import iwl_pkg::*;

    logic       fast_seen_reg;
    logic [7:0] pending_reg;
    logic       lookup_in;
    logic       result_out;

    assign lookup_in  = in_valid && !in_stall && (command == CMD_LOOKUP);
    assign result_out = out_valid && !out_stall;

    // Mirror of the fast-mode register and count of lookups not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fast_seen_reg <= 1'b0;
            pending_reg   <= '0;
        end
        else begin
            if (cfg_valid && cfg_ready && cfg_index == REG_FAST_MODE) begin
                fast_seen_reg <= cfg_data[0];
            end
            if (lookup_in && !result_out) begin
                pending_reg <= pending_reg + 8'd1;
            end
            else if (result_out && !lookup_in) begin
                pending_reg <= pending_reg - 8'd1;
            end
        end
    end

    // No result is shown while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    // A held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample))
        else $error("stalled result changed");

    // Every result answers an earlier lookup
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 8'd0)
        else $error("result without an outstanding lookup");

    // A precise lookup occupies the input while the modulo unit runs
    a_divide_busy: assert property (@(posedge clk) disable iff (!rst_n)
        lookup_in && !fast_seen_reg |=> in_stall)
        else $error("input not stalled during precise index wrap");

endmodule

bind interpolated_wavetable_lookup_core iwl_checker u_iwl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
);

### sim/interpolated_wavetable_lookup_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolated_wavetable_lookup_core_tb: self-checking bench for the core
// Loads the wavetable, runs a short table of directed transactions, then
// sweeps table sizes and both interpolation modes with random writes and
// lookups. Sender and receiver idle at random. Every sample is checked
// against a local interpolation model or a directed row's fixed value.
// ----------------------------------------------------------------------------
module interpolated_wavetable_lookup_core_tb;
    import iwl_pkg::*;

    localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT        = 1000000;
    localparam int NUM_SWEEPS   = 12;
    localparam int PER_SWEEP    = 64;
    localparam int NUM_ROWS     = 15;

    // Directed stimulus row; want is used only where typed is set
    typedef struct packed {
        logic                       cmd;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] value;
        logic [PHASE_W-1:0]         phase;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] want;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [SIZE_W-1:0]            cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         command = CMD_WRITE;
    logic [ADDR_W-1:0]            entry_address = '0;
    logic signed [31:0]           entry_value = '0;
    logic [PHASE_W-1:0]           phase_index = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]   sample;

    // Model state
    logic signed [SAMPLE_W-1:0]   wave_mem [TABLE_DEPTH];
    bit                           written_mask [TABLE_DEPTH];
    logic [SIZE_W-1:0]            model_size = TABLE_SIZE_RST;
    logic                         model_fast = 1'b0;
    logic signed [SAMPLE_W-1:0]   exp_samples [$];

    int                           fail_count = 0;
    int                           cycle_count = 0;
    int                           idle_pct = 0;
    int                           stall_pct = 0;

    stim_row_t directed_rows [NUM_ROWS] = '{
        '{CMD_WRITE,  10'd0,    Q31_MAX,       32'h0000_0000, 1'b0, 32'sd0},
        '{CMD_WRITE,  10'd1,    Q31_MIN,       32'h0000_0000, 1'b0, 32'sd0},
        '{CMD_WRITE,  10'd2,    32'sh1234_5678, 32'hffff_ffff, 1'b0, 32'sd0},
        '{CMD_WRITE,  10'd1023, 32'sd0,        32'h0000_0000, 1'b0, 32'sd0},
        '{CMD_LOOKUP, 10'd0,    32'sd0,        32'h0000_0000, 1'b1, Q31_MAX},
        '{CMD_LOOKUP, 10'd1023, -32'sd1,       32'h0001_0000, 1'b1, Q31_MIN},
        '{CMD_LOOKUP, 10'd0,    32'sd0,        32'h0000_8000, 1'b0, 32'sd0},
        '{CMD_LOOKUP, 10'd0,    32'sd0,        32'h0000_ffff, 1'b0, 32'sd0},
        '{CMD_LOOKUP, 10'd0,    32'sd0,        32'h0001_ffff, 1'b0, 32'sd0},
        '{CMD_LOOKUP, 10'd0,    32'sd0,        32'h03ff_8000, 1'b0, 32'sd0},
        '{CMD_LOOKUP, 10'd0,    32'sd0,        32'hffff_ffff, 1'b0, 32'sd0},
        '{CMD_LOOKUP, 10'd0,    32'sd0,        32'h0400_0000, 1'b1, Q31_MAX},
        '{CMD_WRITE,  10'd3,    -32'sd1,       32'h0000_0000, 1'b0, 32'sd0},
        '{CMD_LOOKUP, 10'd0,    32'sd0,        32'h0002_0000, 1'b1, 32'sh1234_5678},
        '{CMD_LOOKUP, 10'd0,    32'sd0,        32'h0002_c000, 1'b0, 32'sd0}
    };

    interpolated_wavetable_lookup_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .entry_address (entry_address),
        .entry_value   (entry_value),
        .phase_index   (phase_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample)
    );

    // Clock
    always #6 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result checker: each output transaction against the oldest prediction
    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_samples.size() == 0)
            begin
                $error("sample: no transaction expected, actual %h", sample);
                fail_count++;
            end
            else
            begin
                want = exp_samples.pop_front();
                if (sample !== want)
                begin
                    $error("sample mismatch: expected %h, actual %h", want, sample);
                    fail_count++;
                end
            end
        end
    end

    // Size in use after clamping to 1..TABLE_DEPTH
    function automatic int unsigned effective_size();
        int unsigned s;
        s = model_size;
        if (s < 1) s = 1;
        if (s > TABLE_DEPTH) s = TABLE_DEPTH;
        return s;
    endfunction

    // Entries a and b addressed by a phase under the current settings
    function automatic void entry_pair(input logic [PHASE_W-1:0] phase,
                                       output int unsigned ia, output int unsigned ib);
        int unsigned size_eff;
        int unsigned whole;
        size_eff = effective_size();
        whole    = phase[31:16];
        if (model_fast)
        begin
            ia = whole & (size_eff - 1);
            ib = (whole + 1) & (size_eff - 1);
        end
        else
        begin
            ia = whole % size_eff;
            ib = (ia + 1) % size_eff;
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clamp_q31(input longint v);
        if (v > 64'sd2147483647) return Q31_MAX;
        if (v < -64'sd2147483648) return Q31_MIN;
        return 32'(v);
    endfunction

    // Interpolated sample for a lookup
    function automatic logic signed [SAMPLE_W-1:0] interp_sample(input logic [PHASE_W-1:0] phase);
        int unsigned ia;
        int unsigned ib;
        longint      a;
        longint      b;
        longint      d;
        longint      p;
        longint      frac;
        entry_pair(phase, ia, ib);
        a    = longint'(wave_mem[ia]);
        b    = longint'(wave_mem[ib]);
        d    = longint'(clamp_q31(b - a));
        frac = longint'(phase[15:0]);
        if (model_fast)
            p = 2 * (d >>> 16) * (frac >> 1);
        else
            p = ((frac << 15) * d) >>> 31;
        return clamp_q31(a + p);
    endfunction

    // Sample value biased toward the Q31 extremes
    function automatic logic signed [31:0] random_q31();
        case ($urandom_range(7))
            0:       return Q31_MAX;
            1:       return Q31_MIN;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Drive one input transaction and record its effect once accepted
    task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic signed [31:0] value, input logic [PHASE_W-1:0] phase,
                             input logic typed, input logic signed [SAMPLE_W-1:0] want);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        entry_address <= addr;
        entry_value   <= value;
        phase_index   <= phase;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (cmd == CMD_WRITE)
        begin
            wave_mem[addr]     = value;
            written_mask[addr] = 1'b1;
        end
        else
        begin
            exp_samples.push_back(typed ? want : interp_sample(phase));
        end
    endtask

    // Lookup, loading any entry it reads that was never written
    task automatic send_lookup(input logic [PHASE_W-1:0] phase);
        int unsigned ia;
        int unsigned ib;
        entry_pair(phase, ia, ib);
        if (!written_mask[ia])
            send_item(CMD_WRITE, ADDR_W'(ia), random_q31(), $urandom, 1'b0, 32'sd0);
        if (!written_mask[ib])
            send_item(CMD_WRITE, ADDR_W'(ib), random_q31(), $urandom, 1'b0, 32'sd0);
        send_item(CMD_LOOKUP, ADDR_W'($urandom), $urandom, phase, 1'b0, 32'sd0);
    endtask

    // Hold off input until all samples are back and the pipeline is empty
    task automatic drain_results();
        in_valid <= 1'b0;
        while (exp_samples.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_TABLE_SIZE)
            model_size = data;
        else
            model_fast = data[0];
        @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int                size_sel;
        logic              fast_sel;
        int unsigned       size_eff;
        logic [15:0]       frac;
        logic [ADDR_W-1:0] addr;
        int                mode;
        int                idle_tab [4];
        int                stall_tab [4];

        rst_n     <= 1'b0;
        idle_tab  = '{0, 56, 0, 7};
        stall_tab = '{0, 0, 56, 7};
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            wave_mem[i]     = '0;
            written_mask[i] = 1'b0;
        end

        // Reset
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under reset settings
        for (int r = 0; r < NUM_ROWS; r++)
            send_item(directed_rows[r].cmd, directed_rows[r].addr, directed_rows[r].value,
                      directed_rows[r].phase, directed_rows[r].typed, directed_rows[r].want);

        // Sweep table sizes and modes with random traffic
        for (int k = 0; k < NUM_SWEEPS; k++)
        begin
            case (k)
                0:       begin size_sel = 1024; fast_sel = 1'b0; end
                1:       begin size_sel = 1;    fast_sel = 1'b0; end
                2:       begin size_sel = 0;    fast_sel = 1'b0; end
                3:       begin size_sel = 2047; fast_sel = 1'b0; end
                4:       begin size_sel = $urandom_range(1024, 1); fast_sel = 1'b0; end
                5:       begin size_sel = 3;    fast_sel = 1'b0; end
                6:       begin size_sel = 1024; fast_sel = 1'b1; end
                7:       begin size_sel = 2;    fast_sel = 1'b1; end
                8:       begin size_sel = 0;    fast_sel = 1'b1; end
                // mask wrap with a size that is not a power of two
                9:       begin size_sel = 6;    fast_sel = 1'b1; end
                10:      begin size_sel = 1 << $urandom_range(10); fast_sel = 1'b1; end
                default: begin size_sel = 1500; fast_sel = 1'b1; end
            endcase
            drain_results();
            write_register(REG_TABLE_SIZE, SIZE_W'(size_sel));
            write_register(REG_FAST_MODE, SIZE_W'(fast_sel));

            mode      = k % 4;
            idle_pct  = idle_tab[mode];
            stall_pct <= stall_tab[mode];
            size_eff  = effective_size();

            for (int n = 0; n < PER_SWEEP; n++)
            begin
                // one full stop mid-sweep with every sample returned
                if (k == 6 && n == PER_SWEEP / 2)
                    drain_results();
                if ($urandom_range(99) < 30)
                begin
                    if ($urandom_range(1))
                        addr = ADDR_W'($urandom_range(TABLE_DEPTH - 1));
                    else
                        addr = ADDR_W'($urandom_range(size_eff - 1));
                    send_item(CMD_WRITE, addr, random_q31(), $urandom, 1'b0, 32'sd0);
                end
                else
                begin
                    case ($urandom_range(7))
                        0:       frac = 16'h0000;
                        1:       frac = 16'hffff;
                        default: frac = 16'($urandom);
                    endcase
                    send_lookup({16'($urandom), frac});
                end
            end
        end

        drain_results();
        if (fail_count == 0 && exp_samples.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
src/iwl_pkg.sv
src/iwl_front.sv
src/iwl_queue.sv
src/iwl_back.sv
src/interpolated_wavetable_lookup_core.sv
src/iwl_checker.sv
sim/interpolated_wavetable_lookup_core_tb.sv
